// ===== sv/boa_pkg.sv =====
// Shared types and codes of the block owner allocator.
`default_nettype none
package boa_pkg;

    // Request kinds carried in the mode field.
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Operation applied to each table entry during one pass.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_COUNT   = 2'd1;
    localparam logic [1:0] OP_ALLOC   = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // Reset value of the managed block count register.
    localparam logic [6:0] BLOCKS_IN_USE_RESET = 7'd64;

    typedef struct packed {
        logic       mode;
        logic [7:0] owner_id;
        logic [6:0] blocks_needed;
    } req_t;

    typedef struct packed {
        logic       granted;
        logic [6:0] free_blocks;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic set_count;
        logic issue;
        logic commit;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_ready;
    } stat_t;

endpackage
`default_nettype wire

// ===== sv/block_owner_allocator.sv =====
// Top level of the first-fit block owner allocator.
//
// The block keeps a table of NUM_BLOCKS entries, each free or held by an
// owner id. A request word on the req channel either allocates
// blocks_needed blocks to owner_id (granted only if enough managed blocks
// are free, taking the lowest-numbered free ones) or releases every block
// that owner_id holds in the managed range. Each request yields one
// response word on the rsp channel with the grant flag and the free
// managed block count afterwards. Both channels use valid and stall; a
// word moves when valid is high and stall is low.
// Every request makes one pass over the table through a single memory
// read port and write port, and a new request is accepted only after the
// previous request has finished its pass. The response sits in an output
// register, so a stalled receiver only holds the block once a second
// response is ready. After reset the block clears the table with
// req_stall high. Writing blocks_in_use through cfg_we and cfg_wdata
// starts a recount pass during which requests are stalled.
`default_nettype none
module block_owner_allocator
    import boa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int OWNER_BITS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);

    // Table index width; a single-entry table still needs one bit.
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    cmd_t             cmd;
    stat_t            stat;
    logic [IDX_W-1:0] idx;

    // The controller walks the table index and sequences each pass.
    boa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cfg_we    (cfg_we),
        .stat      (stat),
        .cmd       (cmd),
        .idx       (idx)
    );

    // The datapath holds the table, the free count and the response word.
    boa_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .OWNER_BITS (OWNER_BITS),
        .IDX_W      (IDX_W)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .idx       (idx),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== sv/boa_ctrl.sv =====
// Controller state machine that sequences table passes for the allocator.
`default_nettype none
module boa_ctrl
    import boa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int IDX_W      = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic             cfg_we,
    input  wire stat_t            stat,
    output cmd_t                  cmd,
    output logic [IDX_W-1:0]      idx
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PASS   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             is_item_reg, is_item_next;
    logic             pending_reg, pending_next;

    assign idx       = idx_reg;
    assign req_stall = (state_reg != S_IDLE) || pending_reg || cfg_we;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        is_item_next = is_item_reg;
        pending_next = pending_reg || cfg_we;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we || pending_reg)
                begin
                    // A new managed range needs a fresh free count.
                    cmd.set_count = 1'b1;
                    pending_next  = 1'b0;
                    is_item_next  = 1'b0;
                    idx_next      = '0;
                    state_next    = S_PASS;
                end
                else if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    is_item_next = 1'b1;
                    idx_next     = '0;
                    state_next   = S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.issue = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.commit = 1'b1;
                if (!is_item_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reset starts a clearing pass over the whole table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_PASS;
            idx_reg     <= '0;
            is_item_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            is_item_reg <= is_item_next;
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/boa_dpath.sv =====
// Datapath of the allocator: owner table memory, counters and result register.
`default_nettype none
module boa_dpath
    import boa_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int OWNER_BITS = 8,
    parameter int IDX_W      = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire req_t             req,
    input  wire logic             cfg_we,
    input  wire logic [6:0]       cfg_wdata,
    input  wire cmd_t             cmd,
    input  wire logic [IDX_W-1:0] idx,
    output stat_t                 stat,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_t                  rsp
);

    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int WIDE_W = (CNT_W > 7) ? CNT_W : 7;

    logic [OWNER_BITS-1:0] mem [NUM_BLOCKS];

    logic [6:0]            biu_reg;
    logic [CNT_W-1:0]      free_reg;
    logic [CNT_W-1:0]      free_cnt_reg, free_cnt_next;
    logic [6:0]            taken_reg, taken_next;
    logic [1:0]            op_reg;
    logic                  granted_reg;
    logic [OWNER_BITS-1:0] who_reg;
    logic [6:0]            want_reg;
    logic                  proc_valid_reg;
    logic [IDX_W-1:0]      proc_idx_reg;
    logic [OWNER_BITS-1:0] rd_data_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic [WIDE_W-1:0]     managed;
    logic                  in_range;
    logic                  take;
    logic [OWNER_BITS-1:0] new_val;
    logic                  req_granted;
    logic [WIDE_W-1:0]     free_wide;

    assign managed = (WIDE_W'(biu_reg) > WIDE_W'(NUM_BLOCKS)) ? WIDE_W'(NUM_BLOCKS)
                                                                : WIDE_W'(biu_reg);
    assign in_range  = WIDE_W'(proc_idx_reg) < managed;
    assign free_wide = WIDE_W'(free_cnt_reg);

    assign req_granted = !((req.mode == MODE_ALLOC) &&
                           (WIDE_W'(free_reg) < WIDE_W'(req.blocks_needed)));

    always_comb
    begin
        take    = 1'b0;
        new_val = rd_data_reg;
        unique case (op_reg)
            OP_CLEAR:
            begin
                new_val = '0;
            end
            OP_COUNT:
            begin
                new_val = rd_data_reg;
            end
            OP_ALLOC:
            begin
                take = in_range && (rd_data_reg == '0) && (taken_reg < want_reg);
                if (take)
                begin
                    new_val = who_reg;
                end
            end
            OP_RELEASE:
            begin
                if (in_range && (rd_data_reg == who_reg))
                begin
                    new_val = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        free_cnt_next = free_cnt_reg;
        taken_next    = taken_reg;
        if (cmd.load_req || cmd.set_count)
        begin
            free_cnt_next = '0;
            taken_next    = '0;
        end
        else if (proc_valid_reg)
        begin
            if (in_range && (new_val == '0))
            begin
                free_cnt_next = free_cnt_reg + 1'b1;
            end
            if (take)
            begin
                taken_next = taken_reg + 1'b1;
            end
        end
    end

    // Table memory: one registered read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= mem[idx];
        end
        if (proc_valid_reg && (op_reg != OP_COUNT))
        begin
            mem[proc_idx_reg] <= new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg        <= BLOCKS_IN_USE_RESET;
            free_reg       <= '0;
            free_cnt_reg   <= '0;
            taken_reg      <= '0;
            op_reg         <= OP_CLEAR;
            proc_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                biu_reg <= cfg_wdata;
            end
            if (cmd.load_req)
            begin
                if (req.mode == MODE_RELEASE)
                begin
                    op_reg <= OP_RELEASE;
                end
                else
                begin
                    op_reg <= req_granted ? OP_ALLOC : OP_COUNT;
                end
            end
            else if (cmd.set_count)
            begin
                op_reg <= OP_COUNT;
            end
            if (cmd.commit)
            begin
                free_reg <= free_cnt_reg;
            end
            free_cnt_reg   <= free_cnt_next;
            taken_reg      <= taken_next;
            proc_valid_reg <= cmd.issue;
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= idx;
        if (cmd.load_req)
        begin
            granted_reg <= req_granted;
            who_reg     <= OWNER_BITS'(req.owner_id);
            want_reg    <= req.blocks_needed;
        end
        if (cmd.out_load)
        begin
            rsp_reg.granted     <= granted_reg;
            rsp_reg.free_blocks <= free_wide[6:0];
        end
    end

    assign stat.out_ready = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

endmodule
`default_nettype wire
